// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SALL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true out of reset.
`define SALL_ASSERT_NEVER(label, cond, msg) \
  `SALL_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/core/sall_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list package
// Sizes, command and status codes, and the store write bundle.
// ----------------------------------------------------------------------------
package sall_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic signed [VALUE_W-1:0]  word_t;
  typedef logic [STATUS_W-1:0]        status_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NOT_FOUND   = 3'd1;
  localparam status_t ST_FULL        = 3'd2;
  localparam status_t ST_EMPTY       = 3'd3;
  localparam status_t ST_NOT_IN_LIST = 3'd4;

  // Store update for one cycle: node fill (insert), link patch, used clear.
  typedef struct packed {
    logic  node_we;
    slot_t node_slot;
    word_t node_value;
    slot_t node_link;
    logic  link_we;    // link_slot 0 means head
    slot_t link_slot;
    slot_t link_data;
    logic  clr_we;
    slot_t clr_slot;
  } st_wr_t;

endpackage

// ----- rtl/core/sorted_array_linked_list_core.sv -----
// ----------------------------------------------------------------------------
// Sorted array linked list core
// Walk: insert, search and delete walk one link per cycle; the result is
//   registered when the walk ends; dump gives one result per cycle unless
//   the output stalls. Throughput: one item per walk; the next item is
//   taken the cycle after the final result enters the output register.
// Reset: list empty (head 0, all used flags clear), output register empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_array_linked_list_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  sall_pkg::word_t   value_i,
  input  sall_pkg::slot_t   slot_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sall_pkg::status_t status_o,
  output sall_pkg::slot_t   found_slot_o,
  output sall_pkg::word_t   item_value_o,
  output logic              last_o
);
  import sall_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e  state_q, state_d;
  cmd_e    cmd_q, cmd_d;
  word_t   val_q, val_d;     // operand of insert / search
  slot_t   tgt_q, tgt_d;     // slot to delete
  slot_t   cur_q, cur_d;     // walk pointer
  slot_t   prev_q, prev_d;   // slot whose link points at cur
  slot_t   free_q, free_d;   // slot an insert will take

  logic    out_valid_q, out_valid_d;
  status_t status_q, status_d;
  slot_t   found_q, found_d;
  word_t   item_q, item_d;
  logic    last_q, last_d;

  // store side
  st_wr_t  wr;
  word_t   rd_value;
  slot_t   rd_link;
  slot_t   head;
  slot_t   free_slot;

  // shared compare unit: element at cur vs. operand
  logic    cmp_gt, cmp_eq;

  // result staged this cycle
  logic    emit;
  status_t em_status;
  slot_t   em_slot;
  word_t   em_value;
  logic    em_last;
  logic    out_free;

  sall_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_slot_i   (cur_q),
    .wr_i        (wr),
    .rd_value_o  (rd_value),
    .rd_link_o   (rd_link),
    .head_o      (head),
    .free_slot_o (free_slot)
  );

  sall_cmp u_cmp (
    .a_i  (rd_value),
    .b_i  (val_q),
    .gt_o (cmp_gt),
    .eq_o (cmp_eq)
  );

  // Output register can take a new item when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    free_d      = free_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    found_d     = found_q;
    item_d      = item_q;
    last_d      = last_q;

    wr          = '0;
    emit        = 1'b0;
    em_status   = ST_OK;
    em_slot     = '0;
    em_value    = '0;
    em_last     = 1'b1;

    case (state_q)
      S_IDLE: begin
        // Latch the item and start the walk at the head.
        if (in_valid_i) begin
          cmd_d   = cmd_e'(cmd_i);
          val_d   = value_i;
          tgt_d   = slot_i;
          cur_d   = head;
          prev_d  = '0;
          free_d  = free_slot;
          state_d = S_RUN;
        end
      end

      S_RUN: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (free_q == '0) begin
              emit      = 1'b1;
              em_status = ST_FULL;
            end else if ((cur_q == '0) || cmp_gt) begin
              // Splice the fresh slot in between prev and cur.
              emit           = 1'b1;
              em_slot        = free_q;
              wr.node_we     = out_free;
              wr.node_slot   = free_q;
              wr.node_value  = val_q;
              wr.node_link   = cur_q;
              wr.link_we     = out_free;
              wr.link_slot   = prev_q;
              wr.link_data   = free_q;
            end else begin
              prev_d = cur_q;
              cur_d  = rd_link;
            end
          end

          CMD_SEARCH: begin
            if (cur_q == '0) begin
              emit      = 1'b1;
              em_status = ST_NOT_FOUND;
            end else if (cmp_eq) begin
              emit    = 1'b1;
              em_slot = cur_q;
            end else begin
              cur_d = rd_link;
            end
          end

          CMD_DELETE: begin
            if (cur_q == '0) begin
              // Ran off the end; still at the head means the list was empty.
              emit      = 1'b1;
              em_status = (prev_q == '0) ? ST_EMPTY : ST_NOT_IN_LIST;
            end else if (cur_q == tgt_q) begin
              emit         = 1'b1;
              wr.link_we   = out_free;
              wr.link_slot = prev_q;
              wr.link_data = rd_link;
              wr.clr_we    = out_free;
              wr.clr_slot  = cur_q;
            end else begin
              prev_d = cur_q;
              cur_d  = rd_link;
            end
          end

          CMD_DUMP: begin
            if (cur_q == '0) begin
              emit      = 1'b1;
              em_status = ST_EMPTY;
            end else begin
              // One result per element, advance only as results go out.
              emit     = 1'b1;
              em_slot  = cur_q;
              em_value = rd_value;
              em_last  = (rd_link == '0);
              if (out_free) begin
                cur_d = rd_link;
              end
            end
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Output register: load a staged result, else drain.
    if (emit && out_free) begin
      out_valid_d = 1'b1;
      status_d    = em_status;
      found_d     = em_slot;
      item_d      = em_value;
      last_d      = em_last;
      if (em_last) begin
        state_d = S_IDLE;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_INSERT;
      val_q       <= '0;
      tgt_q       <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= '0;
      item_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      val_q       <= val_d;
      tgt_q       <= tgt_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      found_q     <= found_d;
      item_q      <= item_d;
      last_q      <= last_d;
    end
  end

  // Busy for the whole walk; the output register decouples the result side.
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_slot_o = found_q;
  assign item_value_o = item_q;
  assign last_o       = last_q;

  `SALL_ASSERT(a_take_then_busy, in_valid_i && !in_stall_o |=> in_stall_o, "no walk after take")
  `SALL_ASSERT(a_nonlast_is_dump, out_valid_o && !last_o |-> status_o == ST_OK, "bad partial result")
  `SALL_ASSERT(a_error_fields, out_valid_o && status_o != ST_OK |-> found_slot_o == '0 && item_value_o == '0 && last_o, "error result fields")

endmodule

// ----- rtl/core/sall_cmp.sv -----
// ----------------------------------------------------------------------------
// Sorted list compare unit
// Shared signed magnitude and equality compare used by insert and search walk steps.
// ----------------------------------------------------------------------------
module sall_cmp (
  input  sall_pkg::word_t a_i,
  input  sall_pkg::word_t b_i,
  output logic            gt_o,
  output logic            eq_o
);
  import sall_pkg::*;

  assign gt_o = (a_i > b_i);
  assign eq_o = (a_i == b_i);

endmodule

// ----- rtl/core/sall_store.sv -----
// ----------------------------------------------------------------------------
// Sorted list slot store
// Value and link register files, used flags, head link, lowest free slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sall_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sall_pkg::slot_t  rd_slot_i,
  input  sall_pkg::st_wr_t wr_i,
  output sall_pkg::word_t  rd_value_o,
  output sall_pkg::slot_t  rd_link_o,
  output sall_pkg::slot_t  head_o,
  output sall_pkg::slot_t  free_slot_o
);
  import sall_pkg::*;

  word_t            value_q [SLOTS];
  slot_t            link_q  [SLOTS];
  logic [SLOTS-1:0] used_q;
  slot_t            head_q;
  slot_t            free_slot;

  // Payload files, no reset: only contents of used slots are ever acted on.
  always_ff @(posedge clk_i) begin
    if (wr_i.node_we) begin
      value_q[wr_i.node_slot] <= wr_i.node_value;
    end
  end

  // Node slot and patched slot never coincide (fresh slot vs. used or head).
  always_ff @(posedge clk_i) begin
    if (wr_i.node_we) begin
      link_q[wr_i.node_slot] <= wr_i.node_link;
    end
    if (wr_i.link_we && (wr_i.link_slot != '0)) begin
      link_q[wr_i.link_slot] <= wr_i.link_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= '0;
    end else begin
      if (wr_i.node_we) begin
        used_q[wr_i.node_slot] <= 1'b1;
      end
      if (wr_i.clr_we) begin
        used_q[wr_i.clr_slot] <= 1'b0;
      end
      if (wr_i.link_we && (wr_i.link_slot == '0)) begin
        head_q <= wr_i.link_data;
      end
    end
  end

  // Lowest free slot above the head, 0 when full.
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!used_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_value_o  = value_q[rd_slot_i];
  assign rd_link_o   = link_q[rd_slot_i];
  assign head_o      = head_q;
  assign free_slot_o = free_slot;

  `SALL_ASSERT_NEVER(a_head_slot_unused, used_q[0], "head slot marked used")
  `SALL_ASSERT(a_fill_free_slot, wr_i.node_we |-> !used_q[wr_i.node_slot], "fill of used slot")
  `SALL_ASSERT(a_clear_used_slot, wr_i.clr_we |-> used_q[wr_i.clr_slot], "clear of free slot")

endmodule
